/* design/sorted_priority_queue_top_macros.svh */
// Assertion macros shared by the sorted priority queue RTL.
// Each macro expects clk_i and rst_ni to be in scope.
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/spq_pkg.sv */
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned PrioW  = 16;
  localparam int unsigned OccW   = 5;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } spq_status_e;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic signed [PrioW-1:0]  prio;
  } spq_entry_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic       ins;
    logic       rem;
    spq_entry_t entry;
  } spq_cmd_t;

endpackage

/* design/spq_cell.sv */
`timescale 1ns / 1ps

module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::spq_cmd_t  cmd_i,
  input  logic               occupied_i,
  input  logic               left_take_i,
  input  spq_pkg::spq_entry_t left_i,
  input  spq_pkg::spq_entry_t right_i,
  output logic               take_o,
  output spq_pkg::spq_entry_t entry_o
);

  spq_pkg::spq_entry_t entry_q, entry_d;

  // New entry goes ahead of equal priorities, and into any empty slot.
  assign take_o = !occupied_i ||
                  ($signed(cmd_i.entry.prio) >= $signed(entry_q.prio));

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.rem) begin
      entry_d = right_i;
    end else if (cmd_i.ins && take_o) begin
      entry_d = left_take_i ? left_i : cmd_i.entry;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

/* design/sorted_priority_queue_top.sv */
`timescale 1ns / 1ps
// Sorted priority queue built as a row of DEPTH compare-and-shift cells.
// Input: a transaction is taken on a rising edge with start_i high and busy_o
//   low. kind_i selects insert (value_i, priority_req_i) or remove.
// Output: one result per transaction, shown for exactly one cycle with done_o
//   high, on the cycle after the accepting edge. The receiver
//   cannot stall; results must be captured when done_o is high.
// Throughput: one transaction per cycle. busy_o is held low, since every cell
//   compares the incoming priority against its own entry in parallel and the
//   whole row shifts left or right in the same cycle.
// Order: cell 0 is the front (highest priority). Among equal priorities the
//   latest insert leaves first.
// Status: inserted, removed, remove while empty (value 0), or insert dropped
//   because full (value 0). occupancy_o is the entry count after the
//   transaction, modulo 32.
// Reset: clears the entry count and the result strobe; cell contents are left
//   as they are and never read until written.
module sorted_priority_queue_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                kind_i,
  input  logic signed [31:0]  value_i,
  input  logic signed [15:0]  priority_req_i,
  output logic                done_o,
  output logic signed [31:0]  out_value_o,
  output logic [1:0]          status_o,
  output logic [4:0]          occupancy_o
);

  `include "sorted_priority_queue_top_macros.svh"

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic                accept;
  logic                full, empty;
  logic [CntW-1:0]     count_q, count_d;
  spq_pkg::spq_cmd_t   cmd;
  spq_pkg::spq_entry_t entry [DEPTH];
  logic [DEPTH-1:0]    take;
  logic [DEPTH-1:0]    occupied;

  logic                      done_q;
  logic signed [31:0]        out_value_q, out_value_d;
  spq_pkg::spq_status_e      status_q, status_d;
  logic [spq_pkg::OccW-1:0]  occ_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);

  // Broadcast command: full inserts and empty removes leave the row alone.
  assign cmd.ins         = accept && (kind_i == spq_pkg::KIND_INSERT) && !full;
  assign cmd.rem         = accept && (kind_i == spq_pkg::KIND_REMOVE) && !empty;
  assign cmd.entry.value = value_i;
  assign cmd.entry.prio  = priority_req_i;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::spq_entry_t left, right;
    logic                left_take;

    assign occupied[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_front
      assign left      = cmd.entry;
      assign left_take = 1'b0;
    end else begin : g_mid
      assign left      = entry[i-1];
      assign left_take = take[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign right = entry[i];
    end else begin : g_inner
      assign right = entry[i+1];
    end

    spq_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .occupied_i  (occupied[i]),
      .left_take_i (left_take),
      .left_i      (left),
      .right_i     (right),
      .take_o      (take[i]),
      .entry_o     (entry[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Result of the transaction taken this cycle.
  always_comb begin
    out_value_d = '0;
    status_d    = spq_pkg::ST_INSERTED;
    if (kind_i == spq_pkg::KIND_REMOVE) begin
      if (empty) begin
        status_d = spq_pkg::ST_EMPTY;
      end else begin
        status_d    = spq_pkg::ST_REMOVED;
        out_value_d = entry[0].value;
      end
    end else if (full) begin
      status_d = spq_pkg::ST_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // Result payload, loaded only on an accepted transaction.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_value_q <= out_value_d;
      status_q    <= status_d;
      occ_q       <= spq_pkg::OccW'(count_d);
    end
  end

  assign done_o      = done_q;
  assign out_value_o = out_value_q;
  assign status_o    = status_q;
  assign occupancy_o = occ_q;

  `SPQ_ASSERT_ALWAYS(a_count_bound, count_q <= CntW'(DEPTH), "entry count above DEPTH")
  `SPQ_ASSERT_NEXT(a_done_follows, accept, done_o, "missing result strobe")
  `SPQ_ASSERT_NEXT(a_rem_count, cmd.rem, count_q == $past(count_q) - CntW'(1), "bad remove count")
  `SPQ_ASSERT_ALWAYS(a_full_status, !(done_o && status_o == spq_pkg::ST_FULL) || full, "full drop while not full")

endmodule
